### hdl/gnc_pkg.sv
// Shared constants, types and gradient function for the gradient noise block.
package gnc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W = 8;
  localparam int VAL_W = 32;
  localparam int PROD_W = 2 * VAL_W;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_COL3D = 2'd1;
  localparam logic [1:0] CMD_FLAT = 2'd2;

  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Z = 2'd2;
  localparam logic [1:0] CFG_INV_SCALE = 2'd3;

  localparam logic signed [VAL_W-1:0] ONE = VAL_W'(1) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic start;
    logic flat;
    logic col_start;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } stat_t;

  // Gradient dot product for one hash, with the sixteen-way vector set.
  function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y,
                                input val_t z);
    val_t r;
    r = '0;
    case (h)
      4'd0: r = x + y;
      4'd1: r = -x + y;
      4'd2: r = x - y;
      4'd3: r = -x - y;
      4'd4: r = x + z;
      4'd5: r = -x + z;
      4'd6: r = x - z;
      4'd7: r = -x - z;
      4'd8: r = y + z;
      4'd9: r = -y + z;
      4'd10: r = y - z;
      4'd11: r = -y - z;
      4'd12: r = x + y;
      4'd13: r = -y + z;
      4'd14: r = -x + y;
      4'd15: r = -y - z;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/gnc_ctrl.sv
// Controller sequencing a noise item through the datapath.
module gnc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_command,
  input  logic           in_column_start,
  output logic           out_valid,
  input  logic           out_ready,
  output gnc_pkg::cmd_t  cmd,
  input  gnc_pkg::stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    cmd.start = in_valid && in_ready &&
                (in_command == gnc_pkg::CMD_COL3D || in_command == gnc_pkg::CMD_FLAT);
    cmd.flat = (in_command == gnc_pkg::CMD_FLAT);
    cmd.col_start = in_column_start;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (stat.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

### hdl/gnc_dp.sv
// Datapath: permutation memory, shared multiplier, column cache and final scaling.
module gnc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gnc_pkg::cmd_t       cmd,
  output gnc_pkg::stat_t      stat,
  input  logic                load_we,
  input  logic [7:0]          load_idx,
  input  logic [7:0]          load_val,
  input  logic signed [47:0]  coord_x,
  input  logic signed [47:0]  coord_y,
  input  logic signed [47:0]  coord_z,
  input  logic signed [47:0]  acc_in,
  input  logic [23:0]         off_x,
  input  logic [23:0]         off_y,
  input  logic [23:0]         off_z,
  input  logic [39:0]         inv_scale,
  output logic signed [47:0]  acc_out,
  output logic                sat_out
);

  localparam int F = gnc_pkg::FRAC_BITS;
  localparam int VW = gnc_pkg::VAL_W;
  localparam int PW = gnc_pkg::PROD_W;

  // Steps of the sequencer.
  localparam logic [5:0] P_FX0 = 6'd0, P_FX1 = 6'd1, P_FX2 = 6'd2, P_FX3 = 6'd3;
  localparam logic [5:0] P_FZ0 = 6'd4, P_FZ1 = 6'd5, P_FZ2 = 6'd6, P_FZ3 = 6'd7;
  localparam logic [5:0] P_FY0 = 6'd8, P_FY1 = 6'd9, P_FY2 = 6'd10, P_FY3 = 6'd11;
  localparam logic [5:0] P_HA = 6'd12;
  localparam logic [5:0] P_HB = 6'd13;
  localparam logic [5:0] P_HC = 6'd14;
  localparam logic [5:0] P_HD = 6'd15;
  localparam logic [5:0] P_XL = 6'd16;
  localparam logic [5:0] P_YL0 = 6'd17, P_YL1 = 6'd18, P_ZL = 6'd19;
  localparam logic [5:0] P_SH = 6'd20, P_SL = 6'd21, P_SUM = 6'd22, P_DONE = 6'd23;

  logic [7:0] perm_mem [gnc_pkg::TABLE_SIZE];
  logic [7:0] rd_addr;
  logic [7:0] rd_data_r;

  logic busy_r, busy_nxt;
  logic [5:0] ph_r, ph_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic flat_r, recomp_r, recomp_nxt;
  logic [7:0] px_r, py_r, pz_r, cached_y_r, cached_y_nxt;
  gnc_pkg::val_t dx_r, dy_r, dz_r, fx_r, fy_r, fz_r, t1_r, t2_r;
  gnc_pkg::val_t ga_r, gb_r, n0_r, n1_r;
  gnc_pkg::val_t blend_r [4];
  logic [7:0] pa_r, pb_r;
  logic signed [PW-1:0] r_r;
  logic signed [47:0] acc_r;
  logic signed [47:0] acc_out_r;
  logic sat_r;

  gnc_pkg::val_t ma, mb;
  logic signed [PW-1:0] prod;
  gnc_pkg::val_t mq;

  logic signed [48:0] sx, sy, sz;
  assign sx = 49'(coord_x) + 49'($signed({1'b0, off_x}));
  assign sy = 49'(coord_y) + 49'($signed({1'b0, off_y}));
  assign sz = 49'(coord_z) + 49'($signed({1'b0, off_z}));

  assign prod = PW'(ma) * PW'(mb);
  assign mq = VW'((prod + gnc_pkg::HALF) >>> F);

  logic [7:0] dyo, dzo;
  gnc_pkg::val_t yy, zz;

  always_comb begin
    dyo = flat_r ? 8'd0 : {7'd0, corner_r[0]};
    dzo = flat_r ? {7'd0, corner_r[0]} : {7'd0, corner_r[1]};
    yy = flat_r ? '0 : (dy_r - (corner_r[0] ? gnc_pkg::ONE : '0));
    zz = dz_r - (dzo[0] ? gnc_pkg::ONE : '0);
  end

  // Multiplier operand selection per step and sub-step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (ph_r)
      P_FX0, P_FZ0, P_FY0: begin
        ma = (ph_r == P_FX0) ? dx_r : (ph_r == P_FZ0) ? dz_r : dy_r;
        mb = 6 * ma - 15 * gnc_pkg::ONE;
      end
      P_FX1, P_FZ1, P_FY1: begin
        ma = (ph_r == P_FX1) ? dx_r : (ph_r == P_FZ1) ? dz_r : dy_r;
        mb = ma;
      end
      P_FX2, P_FZ2, P_FY2: begin
        ma = (ph_r == P_FX2) ? dx_r : (ph_r == P_FZ2) ? dz_r : dy_r;
        mb = t2_r;
      end
      P_FX3, P_FZ3, P_FY3: begin
        ma = t1_r;
        mb = t2_r;
      end
      P_XL: begin
        ma = fx_r;
        mb = gb_r - ga_r;
      end
      P_YL0: begin
        ma = fy_r;
        mb = blend_r[1] - blend_r[0];
      end
      P_YL1: begin
        ma = fy_r;
        mb = blend_r[3] - blend_r[2];
      end
      P_ZL: begin
        ma = fz_r;
        mb = n1_r - n0_r;
      end
      P_SH: begin
        ma = n0_r;
        mb = VW'(inv_scale[39:F]);
      end
      P_SL: begin
        ma = n0_r;
        mb = VW'(inv_scale[F-1:0]);
      end
      default: ;
    endcase
  end

  // Hash walk: six table reads per corner, two per step, sub_r counts them.
  always_comb begin
    rd_addr = px_r;
    case (ph_r)
      P_HA: rd_addr = sub_r[0] ? px_r + 8'd1 : px_r;
      P_HB: rd_addr = sub_r[0] ? pb_r + py_r + dyo : pa_r + py_r + dyo;
      P_HC: rd_addr = sub_r[0] ? pb_r + pz_r + dzo : pa_r + pz_r + dzo;
      default: rd_addr = px_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) perm_mem[load_idx] <= load_val;
    rd_data_r <= perm_mem[rd_addr];
  end

  logic signed [49:0] sum;
  assign sum = 50'(acc_r) + 50'($signed(r_r[47:0]));
  logic last_corner;
  assign last_corner = flat_r ? (corner_r == 2'd1) : (corner_r == 2'd3);

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt = ph_r;
    sub_nxt = sub_r;
    corner_nxt = corner_r;
    recomp_nxt = recomp_r;
    cached_y_nxt = cached_y_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      ph_nxt = P_FX0;
      sub_nxt = '0;
      corner_nxt = '0;
    end else if (busy_r) begin
      sub_nxt = '0;
      case (ph_r)
        P_FX3: ph_nxt = P_FZ0;
        P_FZ3: begin
          ph_nxt = flat_r ? P_HA : P_FY0;
        end
        P_FY3: begin
          if (recomp_r) ph_nxt = P_HA;
          else ph_nxt = P_YL0;
          if (recomp_r) cached_y_nxt = py_r;
        end
        P_HA, P_HB, P_HC: begin
          // Table reads return registered data; two reads per step.
          if (sub_r == 2'd3) ph_nxt = ph_r + 6'd1;
          else sub_nxt = sub_r + 2'd1;
        end
        P_HD: ph_nxt = P_XL;
        P_XL: begin
          if (last_corner) ph_nxt = flat_r ? P_ZL : P_YL0;
          else ph_nxt = P_HA;
          corner_nxt = corner_r + 2'd1;
        end
        P_DONE: busy_nxt = 1'b0;
        default: ph_nxt = ph_r + 6'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= P_DONE;
      sub_r <= '0;
      corner_r <= '0;
      cached_y_r <= '0;
      for (int i = 0; i < 4; i++) blend_r[i] <= '0;
    end else begin
      busy_r <= busy_nxt;
      ph_r <= ph_nxt;
      sub_r <= sub_nxt;
      corner_r <= corner_nxt;
      cached_y_r <= cached_y_nxt;
      if (busy_r && ph_r == P_XL && !flat_r) blend_r[corner_r] <= ga_r + mq;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      flat_r <= cmd.flat;
      px_r <= sx[F+7:F];
      pz_r <= sz[F+7:F];
      py_r <= cmd.flat ? 8'd0 : sy[F+7:F];
      dx_r <= VW'({1'b0, sx[F-1:0]});
      dz_r <= VW'({1'b0, sz[F-1:0]});
      dy_r <= cmd.flat ? '0 : VW'({1'b0, sy[F-1:0]});
      acc_r <= acc_in;
    end else if (busy_r) begin
      case (ph_r)
        P_FX0, P_FZ0, P_FY0: t1_r <= mq + 10 * gnc_pkg::ONE;
        P_FX1, P_FZ1, P_FY1: t2_r <= mq;
        P_FX2, P_FZ2, P_FY2: t2_r <= mq;
        P_FX3: fx_r <= mq;
        P_FZ3: fz_r <= mq;
        P_FY3: fy_r <= mq;
        P_HA: begin
          if (sub_r == 2'd1) pa_r <= rd_data_r;
          if (sub_r == 2'd2) pb_r <= rd_data_r;
        end
        P_HB: begin
          if (sub_r == 2'd1) pa_r <= rd_data_r;
          if (sub_r == 2'd2) pb_r <= rd_data_r;
        end
        P_HC: begin
          if (sub_r == 2'd1) ga_r <= gnc_pkg::grad(rd_data_r[3:0], dx_r, yy, zz);
          if (sub_r == 2'd2) gb_r <= gnc_pkg::grad(rd_data_r[3:0], dx_r - gnc_pkg::ONE,
                                                   yy, zz);
        end
        P_XL: begin
          if (flat_r && corner_r[0]) n1_r <= ga_r + mq;
          else if (flat_r) n0_r <= ga_r + mq;
        end
        P_YL0: n0_r <= blend_r[0] + mq;
        P_YL1: n1_r <= blend_r[2] + mq;
        P_ZL: n0_r <= n0_r + mq;
        P_SH: r_r <= prod;
        P_SL: r_r <= r_r + ((prod + gnc_pkg::HALF) >>> F);
        P_SUM: begin
          sat_r <= (sum > 50'sh7FFFFFFFFFFF) || (sum < -50'sh800000000000);
          if (sum > 50'sh7FFFFFFFFFFF) acc_out_r <= 48'sh7FFFFFFFFFFF;
          else if (sum < -50'sh800000000000) acc_out_r <= 48'sh800000000000;
          else acc_out_r <= sum[47:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) recomp_r <= cmd.col_start || (sy[F+7:F] != cached_y_r);
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (ph_r == P_DONE);
  assign acc_out = acc_out_r;
  assign sat_out = sat_r;

endmodule

### hdl/gradient_noise_3d_column_cached.sv
// Top level of the fixed-point 3D gradient noise block with column cache.
// Items arrive on the in_ valid/ready channel. Command 0 writes one entry
// of the permutation table and gives no result. Command 1 takes a 3D
// sample that reuses the four cached x-blended corners while the y cell
// stays the same and in_column_start is low. Command 2 takes a flat
// sample that ignores y. Command 3 is dropped.
// A sample gives one result on the out_ channel: the accumulator plus
// noise times inv_scale, clamped to 48 bits with out_saturated set.
// One item is in flight at a time. A sample's time is set by one
// shared 32x32 multiplier for fades, blends and scaling and by the table
// walk of six reads per corner; a 3D sample that reuses the cache skips
// the table walk and the x blends. A load gives no result and leaves the
// block ready for the next item. The result holds in its output register
// until out_ready is high, and no new item is taken meanwhile; the next
// item can be taken in the cycle after the result leaves. Reset clears
// control state, the column cache and the configuration registers; the
// table is undefined until loaded.
module gradient_noise_3d_column_cached (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_table_value,
  input  logic signed [47:0] in_coord_x,
  input  logic signed [47:0] in_coord_y,
  input  logic signed [47:0] in_coord_z,
  input  logic               in_column_start,
  input  logic signed [47:0] in_accumulator_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_accumulator_out,
  output logic               out_saturated
);

  logic [23:0] off_x_r, off_y_r, off_z_r;
  logic [39:0] inv_scale_r;
  gnc_pkg::cmd_t cmd;
  gnc_pkg::stat_t stat;
  logic load_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      inv_scale_r <= 40'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        gnc_pkg::CFG_OFFSET_X: off_x_r <= cfg_data[23:0];
        gnc_pkg::CFG_OFFSET_Y: off_y_r <= cfg_data[23:0];
        gnc_pkg::CFG_OFFSET_Z: off_z_r <= cfg_data[23:0];
        gnc_pkg::CFG_INV_SCALE: inv_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign load_we = in_valid && in_ready && (in_command == gnc_pkg::CMD_LOAD);

  gnc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_column_start(in_column_start),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  gnc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .load_we(load_we),
    .load_idx(in_table_index), .load_val(in_table_value),
    .coord_x(in_coord_x), .coord_y(in_coord_y), .coord_z(in_coord_z),
    .acc_in(in_accumulator_in), .off_x(off_x_r), .off_y(off_y_r), .off_z(off_z_r),
    .inv_scale(inv_scale_r), .acc_out(out_accumulator_out), .sat_out(out_saturated)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ready) else $error("item accepted while busy");
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_valid) else $error("result not presented after done");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_accumulator_out))
    else $error("result changed while stalled");

endmodule
